>>> hdl/acc_pkg.sv
// Shared constants, types and codes for the access code correlator.
package acc_pkg;

    // Sizing
    localparam int MAX_PATTERN_BITS = 64;
    localparam int CAND_SLOTS       = 16;
    localparam int POSITION_BITS    = 16;

    // Fixed field widths of the ports
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int LEN_FIELD_W = 7;
    localparam int ERR_FIELD_W = 7;
    localparam int CAP_FIELD_W = 5;
    localparam int POS_OUT_W   = 16;
    localparam int ERR_OUT_W   = 7;

    // Derived widths
    localparam int LEN_W       = $clog2(MAX_PATTERN_BITS + 1);
    localparam int DIST_W      = $clog2(MAX_PATTERN_BITS + 1);
    localparam int GROUP_BITS  = 8;
    localparam int NUM_GROUPS  = (MAX_PATTERN_BITS + GROUP_BITS - 1) / GROUP_BITS;
    localparam int GSUM_W      = $clog2(GROUP_BITS + 1);
    localparam int CAND_CNT_W  = $clog2(CAND_SLOTS + 1);
    localparam int CAND_IDX_W  = (CAND_SLOTS > 1) ? $clog2(CAND_SLOTS) : 1;
    localparam int COUNT_LIMIT = (1 << POSITION_BITS) + MAX_PATTERN_BITS;
    localparam int CNT_W       = $clog2(COUNT_LIMIT + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PATTERN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ERRORS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CANDIDATES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXACT_ONLY     = 3'd4;

    // Per-window tag that travels alongside the popcount pipeline
    typedef struct packed {
        logic                     valid;
        logic                     full;
        logic                     in_range;
        logic [POSITION_BITS-1:0] pos;
        logic                     frame_end;
    } acc_tag_t;

    // Search settings handed to the candidate list
    typedef struct packed {
        logic [ERR_FIELD_W-1:0] err_limit;
        logic [CAND_CNT_W-1:0]  cap;
        logic                   exact_mode;
    } acc_cfg_t;

    // Candidate list control
    typedef enum logic {
        ST_RUN,
        ST_EMIT
    } acc_state_t;

endpackage

>>> hdl/acc_in_if.sv
// Input bit channel: one received bit and its frame end mark per item.
interface acc_in_if;
    logic valid;
    logic ready;
    logic bit_value;
    logic frame_end;

    modport source (output valid, output bit_value, output frame_end, input ready);
    modport sink   (input valid, input bit_value, input frame_end, output ready);
endinterface

>>> hdl/acc_out_if.sv
// Result channel: one candidate position or a not-found mark per item.
interface acc_out_if;
    import acc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [POS_OUT_W-1:0] start_position;
    logic [ERR_OUT_W-1:0] error_count;
    logic                 overflow;
    logic                 last_result;

    modport source (output valid, output found, output start_position, output error_count,
                    output overflow, output last_result, input ready);
    modport sink   (input valid, input found, input start_position, input error_count,
                    input overflow, input last_result, output ready);
endinterface

>>> hdl/acc_cfg_if.sv
// Configuration write channel: register index and write data.
interface acc_cfg_if;
    import acc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/access_code_correlator.sv
// Top level: access code search over a bit stream, one bit per item.
//
//  channel  dir  handshake        payload
//  sample   in   valid/ready      bit_value, frame_end
//  result   out  valid/ready      found, start_position, error_count, overflow, last_result
//  cfg      in   valid/ready      index, data (ready is always high)
//
// Bits are taken one per cycle while input is open. The item carrying frame_end
// closes input: its tag passes the first tag stage, two popcount stages and one
// list update, then each result of the list is loaded into the output register in
// turn, and the next bit is taken once the last result is loaded. A stalled result
// holds in the output register and delays the next load. Reset restores the
// register defaults and clears the window, counter and lists at once; no clearing pass.
module access_code_correlator (
    input  logic      clk,
    input  logic      rst_n,
    acc_in_if.sink    sample,
    acc_out_if.source result,
    acc_cfg_if.sink   cfg
);
    import acc_pkg::*;

    // Configuration registers
    logic [CFG_DATA_W-1:0]  target_pattern_reg;
    logic [LEN_FIELD_W-1:0] target_length_reg;
    logic [ERR_FIELD_W-1:0] max_errors_reg;
    logic [CAP_FIELD_W-1:0] max_candidates_reg;
    logic                   exact_only_reg;

    logic                   bit_accept;
    logic                   frame_clear;
    logic                   fe_pending_reg;
    logic [CNT_W-1:0]       bit_cnt_reg;
    logic [LEN_W-1:0]       len_eff;
    logic [CNT_W:0]         cnt_plus;
    logic [CNT_W:0]         pos_full;
    acc_tag_t               tag_next;
    acc_tag_t               tag_s1_reg;
    acc_tag_t               tag_s3;
    acc_cfg_t               list_cfg;
    logic [DIST_W-1:0]      miss_cnt;

    logic [MAX_PATTERN_BITS-1:0] win;
    logic [MAX_PATTERN_BITS-1:0] mismatch;

    assign cfg.ready    = 1'b1;
    assign sample.ready = !fe_pending_reg;
    assign bit_accept   = sample.valid && sample.ready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_pattern_reg <= '0;
            target_length_reg  <= LEN_FIELD_W'(32);
            max_errors_reg     <= '0;
            max_candidates_reg <= CAP_FIELD_W'(16);
            exact_only_reg     <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_TARGET_PATTERN: target_pattern_reg <= cfg.data;
                CFG_TARGET_LENGTH:  target_length_reg  <= cfg.data[LEN_FIELD_W-1:0];
                CFG_MAX_ERRORS:     max_errors_reg     <= cfg.data[ERR_FIELD_W-1:0];
                CFG_MAX_CANDIDATES: max_candidates_reg <= cfg.data[CAP_FIELD_W-1:0];
                CFG_EXACT_ONLY:     exact_only_reg     <= cfg.data[0];
                default:            ;
            endcase
        end
    end

    // Effective code length: zero acts as one, large values saturate
    always_comb
    begin
        if (target_length_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (32'(target_length_reg) > 32'(MAX_PATTERN_BITS))
        begin
            len_eff = LEN_W'(MAX_PATTERN_BITS);
        end
        else
        begin
            len_eff = LEN_W'(target_length_reg);
        end
    end

    // Search settings for the list
    assign list_cfg.err_limit  = max_errors_reg;
    assign list_cfg.exact_mode = exact_only_reg;
    assign list_cfg.cap        = (32'(max_candidates_reg) > 32'(CAND_SLOTS))
                                 ? CAND_CNT_W'(CAND_SLOTS)
                                 : CAND_CNT_W'(max_candidates_reg);

    // Window start position of the incoming bit
    assign cnt_plus = {1'b0, bit_cnt_reg} + (CNT_W+1)'(1);
    assign pos_full = cnt_plus - (CNT_W+1)'(len_eff);

    always_comb
    begin
        tag_next.valid     = bit_accept;
        tag_next.full      = (cnt_plus >= (CNT_W+1)'(len_eff));
        tag_next.in_range  = (pos_full[CNT_W:POSITION_BITS] == '0);
        tag_next.pos       = pos_full[POSITION_BITS-1:0];
        tag_next.frame_end = sample.frame_end;
    end

    // Bit counter, frame-end hold and first tag stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg    <= '0;
            fe_pending_reg <= 1'b0;
            tag_s1_reg     <= '0;
        end
        else
        begin
            tag_s1_reg <= tag_next;
            if (frame_clear)
            begin
                bit_cnt_reg    <= '0;
                fe_pending_reg <= 1'b0;
            end
            else if (bit_accept)
            begin
                if (32'(bit_cnt_reg) < COUNT_LIMIT)
                begin
                    bit_cnt_reg <= bit_cnt_reg + CNT_W'(1);
                end
                if (sample.frame_end)
                begin
                    fe_pending_reg <= 1'b1;
                end
            end
        end
    end

    // Row of window cells, newest bit in cell zero
    for (genvar i = 0; i < MAX_PATTERN_BITS; i++)
    begin : g_cell
        logic shift_src;
        if (i == 0)
        begin : g_head
            assign shift_src = sample.bit_value;
        end
        else
        begin : g_link
            assign shift_src = win[i-1];
        end

        acc_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .shift_in    (shift_src),
            .shift_en    (bit_accept),
            .clear       (frame_clear),
            .pattern_bit (target_pattern_reg[i]),
            .enable      (LEN_W'(i) < len_eff),
            .bit_out     (win[i]),
            .mismatch    (mismatch[i])
        );
    end

    acc_popcount u_popcount (
        .clk      (clk),
        .rst_n    (rst_n),
        .mismatch (mismatch),
        .tag_in   (tag_s1_reg),
        .miss_cnt (miss_cnt),
        .tag_out  (tag_s3)
    );

    acc_list u_list (
        .clk         (clk),
        .rst_n       (rst_n),
        .tag         (tag_s3),
        .miss_cnt    (miss_cnt),
        .cfg         (list_cfg),
        .result      (result),
        .frame_clear (frame_clear)
    );

endmodule

>>> hdl/acc_cell.sv
// One window cell: holds a received bit, passes it on, flags a code mismatch.
module acc_cell (
    input  logic clk,
    input  logic rst_n,
    input  logic shift_in,
    input  logic shift_en,
    input  logic clear,
    input  logic pattern_bit,
    input  logic enable,
    output logic bit_out,
    output logic mismatch
);

    logic bit_reg;

    // Window bit, shifted toward older positions on every accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= 1'b0;
        end
        else if (clear)
        begin
            bit_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            bit_reg <= shift_in;
        end
    end

    assign bit_out  = bit_reg;
    // Only cells inside the code length take part in the distance
    assign mismatch = enable & (bit_reg ^ pattern_bit);

endmodule

>>> hdl/acc_popcount.sv
// Two-stage registered popcount of the cell mismatch flags, tag carried along.
module acc_popcount (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [acc_pkg::MAX_PATTERN_BITS-1:0] mismatch,
    input  acc_pkg::acc_tag_t                    tag_in,
    output logic [acc_pkg::DIST_W-1:0]           miss_cnt,
    output acc_pkg::acc_tag_t                    tag_out
);
    import acc_pkg::*;

    localparam int PAD_BITS = NUM_GROUPS * GROUP_BITS;

    logic [PAD_BITS-1:0] padded;
    logic [GSUM_W-1:0]   grp_next [NUM_GROUPS];
    logic [GSUM_W-1:0]   grp_reg  [NUM_GROUPS];
    acc_tag_t            tag_a_reg;
    logic [DIST_W-1:0]   dist_next;
    logic [DIST_W-1:0]   dist_reg;
    acc_tag_t            tag_b_reg;

    assign padded = PAD_BITS'(mismatch);

    // Stage A: count each group of eight flags
    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_next[g] = '0;
            for (int b = 0; b < GROUP_BITS; b++)
            begin
                grp_next[g] = grp_next[g] + GSUM_W'(padded[g*GROUP_BITS + b]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_reg[g] <= grp_next[g];
        end
    end

    // Stage B: add the group counts
    always_comb
    begin
        dist_next = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            dist_next = dist_next + DIST_W'(grp_reg[g]);
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
    end

    // Tag pipeline, valid bits reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
        end
        else
        begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
        end
    end

    assign miss_cnt = dist_reg;
    assign tag_out  = tag_b_reg;

endmodule

>>> hdl/acc_list.sv
// Candidate lists: records exact and approximate hits, emits one list per frame.
module acc_list (
    input  logic                       clk,
    input  logic                       rst_n,
    input  acc_pkg::acc_tag_t          tag,
    input  logic [acc_pkg::DIST_W-1:0] miss_cnt,
    input  acc_pkg::acc_cfg_t          cfg,
    acc_out_if.source                  result,
    output logic                       frame_clear
);
    import acc_pkg::*;

    // Candidate storage, written only at the fill counts while they are below the cap
    logic [POSITION_BITS-1:0] exact_pos_mem  [CAND_SLOTS];
    logic [POSITION_BITS-1:0] approx_pos_mem [CAND_SLOTS];
    logic [DIST_W-1:0]        approx_err_mem [CAND_SLOTS];

    logic [CAND_CNT_W-1:0] exact_cnt_reg, exact_cnt_next;
    logic [CAND_CNT_W-1:0] approx_cnt_reg, approx_cnt_next;
    logic                  ovf_reg, ovf_next;
    acc_state_t            state_reg, state_next;
    logic [CAND_CNT_W-1:0] idx_reg, idx_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  found_reg;
    logic [POS_OUT_W-1:0]  pos_reg;
    logic [ERR_OUT_W-1:0]  err_reg;
    logic                  out_ovf_reg;
    logic                  last_reg;

    logic                  rec_ok;
    logic                  exact_hit;
    logic                  approx_hit;
    logic [ERR_FIELD_W-1:0] dist_ext;
    logic                  sel_exact;
    logic                  sel_approx;
    logic [CAND_CNT_W-1:0] list_len;
    logic [CAND_IDX_W-1:0] rd_idx;
    logic                  emit_load;
    logic                  is_last;

    assign dist_ext   = ERR_FIELD_W'(miss_cnt);
    assign rec_ok     = tag.valid && tag.full && tag.in_range;
    assign exact_hit  = rec_ok && (miss_cnt == '0) && (exact_cnt_reg < cfg.cap);
    assign approx_hit = rec_ok && (dist_ext <= cfg.err_limit) && (approx_cnt_reg < cfg.cap);

    // Record hits at the current fill positions
    always_ff @(posedge clk)
    begin
        if (exact_hit)
        begin
            exact_pos_mem[exact_cnt_reg[CAND_IDX_W-1:0]] <= tag.pos;
        end
        if (approx_hit)
        begin
            approx_pos_mem[approx_cnt_reg[CAND_IDX_W-1:0]] <= tag.pos;
            approx_err_mem[approx_cnt_reg[CAND_IDX_W-1:0]] <= miss_cnt;
        end
    end

    // List choice; the counts behind it hold while emitting
    assign sel_exact  = (exact_cnt_reg != '0);
    assign sel_approx = !sel_exact && !cfg.exact_mode && (cfg.err_limit != '0)
                        && (approx_cnt_reg != '0);
    assign list_len   = (sel_exact || sel_approx)
                        ? (sel_exact ? exact_cnt_reg : approx_cnt_reg)
                        : CAND_CNT_W'(1);
    assign rd_idx     = idx_reg[CAND_IDX_W-1:0];
    assign emit_load  = (state_reg == ST_EMIT) && (!out_valid_reg || result.ready);
    assign is_last    = (CAND_CNT_W'(idx_reg + CAND_CNT_W'(1)) == list_len);

    // Next state, counts and output valid
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        exact_cnt_next  = exact_cnt_reg;
        approx_cnt_next = approx_cnt_reg;
        ovf_next        = ovf_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        frame_clear     = 1'b0;

        unique case (state_reg)
            ST_RUN:
            begin
                if (exact_hit)
                begin
                    exact_cnt_next = exact_cnt_reg + CAND_CNT_W'(1);
                end
                if (approx_hit)
                begin
                    approx_cnt_next = approx_cnt_reg + CAND_CNT_W'(1);
                end
                if (tag.valid && tag.full && !tag.in_range)
                begin
                    ovf_next = 1'b1;
                end
                if (tag.valid && tag.frame_end)
                begin
                    state_next = ST_EMIT;
                    idx_next   = '0;
                end
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    out_valid_next = 1'b1;
                    idx_next       = idx_reg + CAND_CNT_W'(1);
                    // Frame done: drop all frame state
                    if (is_last)
                    begin
                        state_next      = ST_RUN;
                        exact_cnt_next  = '0;
                        approx_cnt_next = '0;
                        ovf_next        = 1'b0;
                        frame_clear     = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            idx_reg        <= '0;
            exact_cnt_reg  <= '0;
            approx_cnt_reg <= '0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            exact_cnt_reg  <= exact_cnt_next;
            approx_cnt_reg <= approx_cnt_next;
            ovf_reg        <= ovf_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Output payload, read from the chosen list
    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            found_reg   <= sel_exact || sel_approx;
            out_ovf_reg <= ovf_reg;
            last_reg    <= is_last;
            if (sel_exact)
            begin
                pos_reg <= POS_OUT_W'(exact_pos_mem[rd_idx]);
                err_reg <= '0;
            end
            else if (sel_approx)
            begin
                pos_reg <= POS_OUT_W'(approx_pos_mem[rd_idx]);
                err_reg <= ERR_OUT_W'(approx_err_mem[rd_idx]);
            end
            else
            begin
                pos_reg <= '0;
                err_reg <= '0;
            end
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.found          = found_reg;
    assign result.start_position = pos_reg;
    assign result.error_count    = err_reg;
    assign result.overflow       = out_ovf_reg;
    assign result.last_result    = last_reg;

endmodule

>>> hdl/acc_checker.sv
// Port-level checks for the access code correlator, bound to the top level.
module acc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          sample_valid,
    input logic                          sample_ready,
    input logic                          sample_frame_end,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic                          result_found,
    input logic [acc_pkg::POS_OUT_W-1:0] result_start_position,
    input logic [acc_pkg::ERR_OUT_W-1:0] result_error_count,
    input logic                          result_overflow,
    input logic                          result_last_result,
    input logic                          cfg_ready
);
    import acc_pkg::*;

    // A stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_found)
            && $stable(result_start_position) && $stable(result_error_count)
            && $stable(result_overflow) && $stable(result_last_result))
        else $error("result changed while stalled");

    // A not-found result stands alone with zero position and count
    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_found |-> result_last_result
            && (result_start_position == '0) && (result_error_count == '0))
        else $error("malformed not-found result");

    // Input closes right after a frame's final bit
    a_frame_close: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready && sample_frame_end |=> !sample_ready)
        else $error("input open after frame end");

    // Configuration writes never stall
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port stalled");

endmodule

bind access_code_correlator acc_checker u_acc_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .sample_valid          (sample.valid),
    .sample_ready          (sample.ready),
    .sample_frame_end      (sample.frame_end),
    .result_valid          (result.valid),
    .result_ready          (result.ready),
    .result_found          (result.found),
    .result_start_position (result.start_position),
    .result_error_count    (result.error_count),
    .result_overflow       (result.overflow),
    .result_last_result    (result.last_result),
    .cfg_ready             (cfg.ready)
);
